// ----- src/encoder_button_event_queue_top_defines.svh -----
// assertion macros for the encoder button event queue
// no dependencies; included by the files that carry assertions
`ifndef ENCODER_BUTTON_EVENT_QUEUE_TOP_DEFINES_SVH
`define ENCODER_BUTTON_EVENT_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define EBQ_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define EBQ_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication failed");
`define EBQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define EBQ_ASSERT(lbl, ck, rstn, prop)
`define EBQ_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define EBQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif

`endif

// ----- src/ebq_pkg.sv -----
// shared types, codes and constants for the encoder button event queue
// no dependencies
package ebq_pkg;

	localparam int FIFO_DEPTH_DEF = 16;
	localparam int CODE_W = 3;
	localparam int COUNT_OUT_W = 5;
	localparam logic [15:0] DEBOUNCE_RST = 16'd50;

	typedef enum logic [2:0] {
		CMD_EDGE      = 3'd0,
		CMD_POP       = 3'd1,
		CMD_FLUSH     = 3'd2,
		CMD_IDLE      = 3'd3,
		CMD_RESET_ACT = 3'd4
	} cmd_t;

	localparam logic [CODE_W-1:0] EV_NONE    = 3'd0;
	localparam logic [CODE_W-1:0] EV_CW      = 3'd1;
	localparam logic [CODE_W-1:0] EV_CCW     = 3'd2;
	localparam logic [CODE_W-1:0] EV_PUSH    = 3'd3;

	localparam logic [1:0] SRC_ENCODER = 2'd0;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic              flush;
		logic [CODE_W-1:0] code;
	} fifo_req_t;

	function automatic logic [CODE_W-1:0] edge_code(input logic [1:0] src, input logic b);
		logic [CODE_W-1:0] c;
		if (src == SRC_ENCODER) begin
			c = b ? EV_CCW : EV_CW;
		end else begin
			c = EV_PUSH + CODE_W'(src - 2'd1);
		end
		return c;
	endfunction

endpackage

// ----- src/encoder_button_event_queue_top.sv -----
// encoder button event queue: input stage, command decode, result register
// depends on ebq_pkg, ebq_debounce, ebq_fifo and the assertion macro header
//
// usage
//  - input channel in_valid/in_ready carries one command word: cmd, source,
//    b_level, time_ms; output channel out_valid/out_ready returns one result
//    word per command: event_code, accepted, dropped, queue_count, idle_ms
//  - cfg_we/cfg_wdata write the debounce interval in ms, taken at once; the user
//    writes it only while no command is in flight, the block does not enforce it
//  - flow: a word accepted is held in the input stage, is executed from there
//    once the result register can take it, and its result is presented from it
//  - throughput: one command per cycle unless stalled, set by the single
//    execute stage: lockout compare, one fifo memory access, state update
//  - stall: the result register holds while out_ready is low; one more word
//    is taken into the input stage, then in_ready drops until out_ready
//  - reset: debounce interval 50, source timers and activity time zero,
//    fifo empty; fifo memory has no reset and is only read where written
`include "encoder_button_event_queue_top_defines.svh"
module encoder_button_event_queue_top #(
	parameter int FIFO_DEPTH = ebq_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [1:0]  source,
	input  logic        b_level,
	input  logic [31:0] time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_code,
	output logic        accepted,
	output logic        dropped,
	output logic [4:0]  queue_count,
	output logic [31:0] idle_ms
);
	import ebq_pkg::*;

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic              valid_s1;
	logic [2:0]        cmd_s1;
	logic [1:0]        source_s1;
	logic              b_s1;
	logic [31:0]       time_s1;

	logic              valid_s2;
	logic              pop_ok_s2;
	logic              acc_s2;
	logic              drop_s2;
	logic [4:0]        count_s2;
	logic [31:0]       idle_s2;

	logic [31:0]       act_time_q;

	logic              advance;
	logic              is_edge;
	logic              hit;
	logic              full;
	logic              pop_ok;
	logic [CW-1:0]     count_next;
	logic [CW+4:0]     count_ext;
	logic [CODE_W-1:0] rd_data;
	logic [31:0]       idle_d;
	fifo_req_t         req;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign is_edge  = cmd_s1 == CMD_EDGE;

	always_comb begin
		req.push  = advance && is_edge && hit;
		req.pop   = advance && (cmd_s1 == CMD_POP);
		req.flush = advance && (cmd_s1 == CMD_FLUSH);
		req.code  = edge_code(source_s1, b_s1);
	end

	assign idle_d    = (cmd_s1 == CMD_IDLE) ? time_s1 - act_time_q : '0;
	assign count_ext = {5'b0, count_next};

	ebq_debounce u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.check     (advance && is_edge),
		.source    (source_s1),
		.now       (time_s1),
		.hit       (hit)
	);

	ebq_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.full       (full),
		.pop_ok     (pop_ok),
		.count_next (count_next),
		.rd_data    (rd_data)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1    <= cmd;
			source_s1 <= source;
			b_s1      <= b_level;
			time_s1   <= time_ms;
		end
	end

	// activity time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_time_q <= '0;
		end else if (pop_ok || (advance && cmd_s1 == CMD_RESET_ACT)) begin
			act_time_q <= time_s1;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pop_ok_s2 <= pop_ok;
			acc_s2    <= is_edge && hit;
			drop_s2   <= is_edge && hit && full;
			count_s2  <= count_ext[4:0];
			idle_s2   <= idle_d;
		end
	end

	assign out_valid   = valid_s2;
	assign event_code  = pop_ok_s2 ? rd_data : EV_NONE;
	assign accepted    = acc_s2;
	assign dropped     = drop_s2;
	assign queue_count = count_s2;
	assign idle_ms     = idle_s2;

	`EBQ_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(time_s1) && $stable(cmd_s1))
	`EBQ_ASSERT_IMPL(a_drop_acc, clk, arst_n, valid_s2 && drop_s2, acc_s2)

endmodule

// ----- src/ebq_debounce.sv -----
// per-source lockout timers and the debounce interval register
// depends on ebq_pkg
module ebq_debounce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        check,
	input  logic [1:0]  source,
	input  logic [31:0] now,
	output logic        hit
);
	import ebq_pkg::*;

	logic [15:0] debounce_q;
	logic [31:0] last_q [4];
	logic [31:0] diff;

	assign diff = now - last_q[source];
	assign hit  = diff >= {16'b0, debounce_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				last_q[i] <= '0;
			end
		end else if (check && hit) begin
			last_q[source] <= now;
		end
	end

endmodule

// ----- src/ebq_fifo.sv -----
// event fifo: pointers, fill count and the event memory with registered read
// depends on ebq_pkg and the assertion macro header
`include "encoder_button_event_queue_top_defines.svh"
module ebq_fifo #(
	parameter int DEPTH = ebq_pkg::FIFO_DEPTH_DEF,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ebq_pkg::fifo_req_t        req,
	output logic                      full,
	output logic                      pop_ok,
	output logic [CW-1:0]             count_next,
	output logic [ebq_pkg::CODE_W-1:0] rd_data
);
	import ebq_pkg::*;

	logic [CODE_W-1:0] mem [DEPTH];
	logic [CODE_W-1:0] rd_data_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW-1:0]     wr_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              push_ok;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full    = cnt_q == CW'(DEPTH);
	assign push_ok = req.push && !full;
	assign pop_ok  = req.pop && (cnt_q != '0);
	assign rd_data = rd_data_q;

	always_comb begin
		priority if (req.flush) begin
			count_next = '0;
		end else if (push_ok) begin
			count_next = cnt_q + CW'(1);
		end else if (pop_ok) begin
			count_next = cnt_q - CW'(1);
		end else begin
			count_next = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			cnt_q <= count_next;
			if (req.flush) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end else begin
				if (push_ok) begin
					wr_ptr_q <= nxt(wr_ptr_q);
				end
				if (pop_ok) begin
					rd_ptr_q <= nxt(rd_ptr_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_ptr_q] <= req.code;
		end
		if (pop_ok) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	`EBQ_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`EBQ_ASSERT_IMPL(a_empty_ptrs, clk, arst_n, cnt_q == '0, rd_ptr_q == wr_ptr_q)
	`EBQ_ASSERT_NEXT(a_flush_empty, clk, arst_n, req.flush, cnt_q == '0)
	`EBQ_ASSERT_NEXT(a_full_hold, clk, arst_n, req.push && full && !req.flush,
		cnt_q == $past(cnt_q))

endmodule
